/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file sfp64_chk.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/sfp64_pkg.sv */
// ----------------------------------------------------------------------------
// sfp64_pkg
// Types, codes and the control program of the 64-bit add-rotate-xor generator.
// ----------------------------------------------------------------------------
package sfp64_pkg;

    typedef logic [63:0] word_t;

    // Item operation codes
    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_LIMBS = 2'd2;

    localparam word_t      SEED_A_INIT   = 64'h0000_0000_f1ea_5eed;
    localparam logic [5:0] WARMUP_LAST   = 6'd19;   // twenty warm-up rounds
    localparam logic [6:0] DIGIT_BITS_RST = 7'd60;

    // Program addresses
    localparam logic [1:0] PC_IDLE = 2'd0;
    localparam logic [1:0] PC_WARM = 2'd1;
    localparam logic [1:0] PC_DRAW = 2'd2;
    localparam logic [1:0] PC_LIMB = 2'd3;

    // Jump conditions
    localparam logic [1:0] COND_DISPATCH = 2'd0;  // branch on the accepted op
    localparam logic [1:0] COND_LOOP     = 2'd1;  // to target while count nonzero, else idle
    localparam logic [1:0] COND_IDLE     = 2'd2;  // back to idle

    typedef struct packed {
        logic       round_en;
        logic       emit;
        logic       use_mask;
        logic       cnt_dec;
        logic [1:0] cond;
        logic [1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t rom_word(input logic [1:0] pc);
        ctrl_word_t cw;
        cw = '0;
        unique case (pc)
            PC_IDLE:
            begin
                cw.cond = COND_DISPATCH;
            end
            PC_WARM:
            begin
                cw.round_en = 1'b1;
                cw.cnt_dec  = 1'b1;
                cw.cond     = COND_LOOP;
                cw.target   = PC_WARM;
            end
            PC_DRAW:
            begin
                cw.round_en = 1'b1;
                cw.emit     = 1'b1;
                cw.cond     = COND_IDLE;
            end
            PC_LIMB:
            begin
                cw.round_en = 1'b1;
                cw.emit     = 1'b1;
                cw.use_mask = 1'b1;
                cw.cnt_dec  = 1'b1;
                cw.cond     = COND_LOOP;
                cw.target   = PC_LIMB;
            end
            default:
            begin
                cw.cond = COND_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

/* hw/rtl/small_fast_prng_64.sv */
// ----------------------------------------------------------------------------
// small_fast_prng_64
// Four-word add-rotate-xor generator run by a four-step control program.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op, seed_value, limb_count.
//   An item is taken only while the sequencer sits in its idle step, so
//   in_stall is high while an item is being worked.
//   Seed: loads the state at acceptance, then 20 rounds, one per cycle; no
//   result; the next item is taken only once the warm-up rounds are done.
//   Draw: one round in the draw step that follows acceptance, its result
//   registered into the output register at the end of that step; the next
//   item is taken only after the sequencer returns to idle.
//   Limbs: N rounds (N capped at MAX_LIMBS), one result per cycle unless
//   the output stalls, highest limb first, last on limb 0. Zero limbs and
//   op 3 give nothing. One state round per cycle, in the single round unit.
//   Output channel (out_valid / out_stall) is a single output register; a
//   stalled result holds, and the sequencer waits in its emitting step.
//   digit_bits is written through cfg_wr_en / cfg_wr_data; the user must
//   do so only while idle, as the block does not enforce it. Reset clears
//   the state words, the sequencer and out_valid, and sets digit_bits to 60.
// ----------------------------------------------------------------------------
module small_fast_prng_64 #(
    parameter int MAX_LIMBS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  sfp64_pkg::word_t    seed_value,
    input  logic [6:0]          limb_count,
    output logic                out_valid,
    input  logic                out_stall,
    output sfp64_pkg::word_t    value,
    output logic [5:0]          limb_index,
    output logic                last,
    input  logic                cfg_wr_en,
    input  logic [6:0]          cfg_wr_data
);
    import sfp64_pkg::*;

    localparam logic [6:0] LIMB_MAX = 7'(MAX_LIMBS);

    logic [1:0]  pc_reg, pc_next;
    logic [5:0]  cnt_reg, cnt_next;
    word_t       a_reg, b_reg, c_reg, d_reg;
    word_t       e_w, a_rnd, b_rnd, c_rnd, d_rnd;
    logic [6:0]  digit_bits_reg;
    logic        out_valid_reg;
    word_t       value_reg;
    logic [5:0]  limb_index_reg;
    logic        last_reg;
    ctrl_word_t  cw;
    logic        accept, step_go;
    logic [6:0]  count_sat;
    word_t       mask;

    assign cw       = rom_word(pc_reg);
    assign in_stall = (pc_reg != PC_IDLE);
    assign accept   = in_valid && (pc_reg == PC_IDLE);
    // hold an emitting step while the output register is full and stalled
    assign step_go  = !(cw.emit && out_valid_reg && out_stall);

    assign count_sat = (limb_count > LIMB_MAX) ? LIMB_MAX : limb_count;
    assign mask = digit_bits_reg[6] ? '1 : ~({64{1'b1}} << digit_bits_reg[5:0]);

    // one round
    always_comb
    begin
        e_w   = a_reg - {b_reg[56:0], b_reg[63:57]};
        a_rnd = b_reg ^ {c_reg[50:0], c_reg[63:51]};
        b_rnd = c_reg + {d_reg[26:0], d_reg[63:27]};
        c_rnd = d_reg + e_w;
        d_rnd = e_w + a_rnd;
    end

    // sequencer
    always_comb
    begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        if (step_go)
        begin
            unique case (cw.cond)
                COND_DISPATCH:
                begin
                    if (accept)
                    begin
                        priority if (op == OP_SEED)
                        begin
                            pc_next  = PC_WARM;
                            cnt_next = WARMUP_LAST;
                        end
                        else if (op == OP_DRAW)
                        begin
                            pc_next = PC_DRAW;
                        end
                        else if (op == OP_LIMBS && limb_count != 7'd0)
                        begin
                            pc_next  = PC_LIMB;
                            cnt_next = 6'(count_sat - 7'd1);
                        end
                        else
                        begin
                            pc_next = PC_IDLE;
                        end
                    end
                end
                COND_LOOP:
                begin
                    pc_next = (cnt_reg != 6'd0) ? cw.target : PC_IDLE;
                end
                COND_IDLE:
                begin
                    pc_next = PC_IDLE;
                end
                default:
                begin
                    pc_next = PC_IDLE;
                end
            endcase
            if (cw.cnt_dec)
            begin
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= PC_IDLE;
            cnt_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            d_reg          <= '0;
            digit_bits_reg <= DIGIT_BITS_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
            if (cfg_wr_en)
            begin
                digit_bits_reg <= cfg_wr_data;
            end
            if (accept && op == OP_SEED)
            begin
                a_reg <= SEED_A_INIT;
                b_reg <= seed_value;
                c_reg <= seed_value;
                d_reg <= seed_value;
            end
            else if (step_go && cw.round_en)
            begin
                a_reg <= a_rnd;
                b_reg <= b_rnd;
                c_reg <= c_rnd;
                d_reg <= d_rnd;
            end
            if (step_go && cw.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step_go && cw.emit)
        begin
            value_reg      <= cw.use_mask ? (d_rnd & mask) : d_rnd;
            limb_index_reg <= cw.use_mask ? cnt_reg : 6'd0;
            last_reg       <= cw.use_mask ? (cnt_reg == 6'd0) : 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign limb_index = limb_index_reg;
    assign last       = last_reg;

endmodule

/* hw/rtl/sfp64_chk.sv */
// ----------------------------------------------------------------------------
// sfp64_chk
// Port-level checks for the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfp64_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [1:0]       op,
    input logic [6:0]       limb_count,
    input logic             out_valid,
    input logic             out_stall,
    input sfp64_pkg::word_t value,
    input logic [5:0]       limb_index,
    input logic             last
);
    import sfp64_pkg::*;

    logic accept_work;

    // accepted item that starts a program run
    assign accept_work = in_valid && !in_stall &&
        (op == OP_SEED || op == OP_DRAW || (op == OP_LIMBS && limb_count != 7'd0));

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(value))
    `ASSERT_NEXT(a_tag_hold, clk, rst_n, out_valid && out_stall,
        $stable(limb_index) && $stable(last))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept_work, in_stall)
    `ASSERT_IMPLY(a_last_is_limb0, clk, rst_n, out_valid && last, limb_index == 6'd0)

endmodule

bind small_fast_prng_64 sfp64_chk u_sfp64_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .limb_count (limb_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .limb_index (limb_index),
    .last       (last)
);
